// ----- hw/rtl/mgs_pkg.sv -----
// shared types and constants for the masked grid smoother
`timescale 1ns / 1ps
package mgs_pkg;
	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_PASSES_DEF = 4;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int EDGE_W = 4096;
	localparam int DIAG_W = 2896;
	localparam int TOT_BITS = 20;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_COLUMNS = 3'd0,
		REG_ROWS = 3'd1,
		REG_WEIGHT = 3'd2,
		REG_PASSES = 3'd3,
		REG_MISSING = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_READ,
		ST_CALC,
		ST_DIV
	} stage_state_t;

	typedef struct packed {
		logic [8:0] columns;
		logic [15:0] rows;
		logic [15:0] weight;
		logic [2:0] passes;
	} geom_t;
endpackage

// ----- hw/rtl/mgs_front.sv -----
// input front end: config registers, token classification and token queue
`timescale 1ns / 1ps
module mgs_front #(
	parameter int MAX_COLUMNS = mgs_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_PASSES = mgs_pkg::MAX_PASSES_DEF,
	parameter int SAMPLE_BITS = mgs_pkg::SAMPLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic signed [SAMPLE_BITS-1:0] sample,
	output mgs_pkg::geom_t geom,
	output logic signed [SAMPLE_BITS-1:0] missing,
	output logic clear,
	output logic tok_valid,
	input logic tok_ready,
	output logic tok_has,
	output logic signed [SAMPLE_BITS-1:0] tok_value
);
	import mgs_pkg::*;
	localparam int QW = $clog2(QUEUE_DEPTH);
	geom_t geom_q;
	logic signed [SAMPLE_BITS-1:0] missing_q;
	logic clear_q;
	logic [SAMPLE_BITS:0] q_mem [QUEUE_DEPTH];
	logic [QW-1:0] wr_q, rd_q;
	logic [QW:0] cnt_q;
	logic push, pop;
	logic [8:0] col_sat;
	logic [2:0] pass_sat;

	assign cfg_ready = 1'b1;
	assign in_ready = cnt_q != (QW+1)'(QUEUE_DEPTH) && !clear_q;
	assign push = in_valid && in_ready;
	assign pop = tok_valid && tok_ready;
	assign tok_valid = cnt_q != '0;
	assign tok_has = q_mem[rd_q][SAMPLE_BITS];
	assign tok_value = q_mem[rd_q][SAMPLE_BITS-1:0];
	assign geom = geom_q;
	assign missing = missing_q;
	assign clear = clear_q;
	assign col_sat = (cfg_data[8:0] < 9'd2) ? 9'd2 :
		(32'(cfg_data[8:0]) > MAX_COLUMNS) ? 9'(MAX_COLUMNS) : cfg_data[8:0];
	assign pass_sat = (32'(cfg_data[2:0]) > MAX_PASSES) ? 3'(MAX_PASSES) : cfg_data[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.columns <= 9'(MAX_COLUMNS > 256 ? 256 : MAX_COLUMNS);
			geom_q.rows <= 16'd256;
			geom_q.weight <= 16'd4096;
			geom_q.passes <= 3'(MAX_PASSES > 1 ? 1 : MAX_PASSES);
			missing_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			clear_q <= 1'b0;
		end else begin
			clear_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_COLUMNS: begin
						geom_q.columns <= col_sat;
						clear_q <= 1'b1;
					end
					REG_ROWS: begin
						geom_q.rows <= (cfg_data < 16'd2) ? 16'd2 : cfg_data;
						clear_q <= 1'b1;
					end
					REG_WEIGHT: geom_q.weight <= cfg_data;
					REG_PASSES: begin
						geom_q.passes <= pass_sat;
						clear_q <= 1'b1;
					end
					REG_MISSING: missing_q <= SAMPLE_BITS'($signed(cfg_data));
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else if (clear_q) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= {~cmd, sample};
	end

	ast_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
	ast_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == (QW+1)'(QUEUE_DEPTH) |-> !in_ready) else $error("accept while full");
	ast_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !tok_valid) else $error("pop while empty");
endmodule

// ----- hw/rtl/mgs_stage.sv -----
// one smoothing pass: line ring memory, neighbor gather and serial divider
`timescale 1ns / 1ps
module mgs_stage #(
	parameter int MAX_COLUMNS = mgs_pkg::MAX_COLUMNS_DEF,
	parameter int SAMPLE_BITS = mgs_pkg::SAMPLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input mgs_pkg::geom_t geom,
	input logic signed [SAMPLE_BITS-1:0] missing,
	input logic clear,
	input logic in_valid,
	output logic in_ready,
	input logic in_has,
	input logic signed [SAMPLE_BITS-1:0] in_value,
	output logic out_valid,
	input logic out_ready,
	output logic out_has,
	output logic signed [SAMPLE_BITS-1:0] out_value,
	output logic out_last
);
	import mgs_pkg::*;
	localparam int BUF_LEN = 2 * MAX_COLUMNS + 4;
	localparam int AW = $clog2(BUF_LEN);
	localparam int PW = AW + 1;
	localparam int AB = SAMPLE_BITS + TOT_BITS + 5;
	localparam int QB = AB;
	localparam int NB = AB + 1;

	stage_state_t state_q, state_d;
	logic signed [SAMPLE_BITS-1:0] mem [BUF_LEN];
	logic [AW-1:0] head_q;
	logic [PW-1:0] pend_q;
	logic [15:0] row_q;
	logic [8:0] col_q;
	logic [3:0] k_q;
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic signed [SAMPLE_BITS-1:0] centre_q;
	logic signed [AB-1:0] acc_q;
	logic [TOT_BITS-1:0] tot_q;
	logic [NB-1:0] num_q;
	logic [NB-1:0] rem_q;
	logic [QB-1:0] quo_q;
	logic [6:0] bit_q;
	logic neg_q;
	logic last_q;
	logic ovalid_q, ohas_q;
	logic signed [SAMPLE_BITS-1:0] oval_q;
	logic olast_q;
	logic [PW-1:0] need;
	logic ready_go, take, emit_free;
	logic [AW:0] rd_addr_w;
	logic [AW-1:0] rd_addr;
	logic [1:0] dr, dc;
	logic kvalid;
	logic [15:0] wsel;
	logic [AW:0] wr_sum;
	logic [NB:0] trial;
	logic [QB-1:0] lim;
	logic signed [SAMPLE_BITS-1:0] qsat;
	logic [PW-1:0] pend_add;
	logic [AW+9:0] off;
	logic kv_d;
	logic [15:0] w_d;

	assign emit_free = !ovalid_q || out_ready;
	assign need = ((row_q + 16'd1 < geom.rows) ? PW'(geom.columns) : PW'(0))
		+ PW'(col_q + 9'd1 < geom.columns);
	assign ready_go = pend_q > need;
	assign in_ready = state_q == ST_RUN && emit_free && !clear;
	assign take = in_valid && in_ready;
	assign pend_add = pend_q + PW'(take && in_has);
	assign wr_sum = (AW+1)'(head_q) + (AW+1)'(pend_q);

	assign dr = (k_q >= 4'd6) ? 2'd2 : (k_q >= 4'd3) ? 2'd1 : 2'd0;
	assign dc = 2'(k_q - 4'(dr) * 4'd3);
	assign off = (AW+10)'(head_q) + (AW+10)'(BUF_LEN) - (AW+10)'(geom.columns) - 1'b1
		+ (AW+10)'(dr) * (AW+10)'(geom.columns) + (AW+10)'(dc);
	assign rd_addr_w = (off >= (AW+10)'(2 * BUF_LEN)) ? (AW+1)'(off - (AW+10)'(2 * BUF_LEN))
		: (off >= (AW+10)'(BUF_LEN)) ? (AW+1)'(off - (AW+10)'(BUF_LEN))
		: (AW+1)'(off);
	assign rd_addr = rd_addr_w[AW-1:0];
	assign kvalid = !((dr == 2'd0 && row_q == 16'd0) || (dr == 2'd2 && row_q + 16'd1 >= geom.rows)
		|| (dc == 2'd0 && col_q == 9'd0) || (dc == 2'd2 && col_q + 9'd1 >= geom.columns));
	assign wsel = (dr == 2'd1 && dc == 2'd1) ? geom.weight
		: (dr == 2'd1 || dc == 2'd1) ? 16'(EDGE_W) : 16'(DIAG_W);
	assign trial = {rem_q, num_q[NB-1]} - {(NB-TOT_BITS)'(0), tot_q, 1'b0};
	assign lim = QB'(1) << (SAMPLE_BITS - 1);
	assign qsat = neg_q ? ((quo_q > lim) ? SAMPLE_BITS'(-$signed({1'b0, lim}))
		: SAMPLE_BITS'(-$signed({1'b0, quo_q})))
		: ((quo_q > lim - 1'b1) ? SAMPLE_BITS'(lim - 1'b1) : SAMPLE_BITS'(quo_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: if (take && pend_add > need && pend_add != '0) state_d = ST_READ;
			ST_READ: state_d = ST_CALC;
			ST_CALC: if (k_q == 4'd10) state_d = ST_DIV;
			ST_DIV: if (bit_q == 7'd0 && emit_free) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			head_q <= '0;
			pend_q <= '0;
			row_q <= '0;
			col_q <= '0;
			ovalid_q <= 1'b0;
		end else if (clear) begin
			state_q <= ST_RUN;
			head_q <= '0;
			pend_q <= '0;
			row_q <= '0;
			col_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ready) ovalid_q <= 1'b0;
			if (take) begin
				pend_q <= pend_add;
				if (!(pend_add > need && pend_add != '0)) begin
					ovalid_q <= 1'b1;
				end
			end
			if (state_q == ST_DIV && bit_q == 7'd0 && emit_free) begin
				ovalid_q <= 1'b1;
				head_q <= (32'(head_q) + 1 >= BUF_LEN) ? '0 : head_q + 1'b1;
				pend_q <= pend_q - 1'b1;
				if (col_q + 9'd1 >= geom.columns) begin
					col_q <= '0;
					row_q <= (row_q + 16'd1 >= geom.rows) ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + 9'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_has)
			mem[(wr_sum >= (AW+1)'(BUF_LEN)) ? AW'(wr_sum - (AW+1)'(BUF_LEN))
				: AW'(wr_sum)] <= in_value;
		rd_s1 <= mem[rd_addr];
		if (take) begin
			ohas_q <= 1'b0;
			oval_q <= in_value;
			olast_q <= 1'b0;
			k_q <= 4'd0;
			acc_q <= '0;
			tot_q <= '0;
			last_q <= row_q + 16'd1 == geom.rows && col_q + 9'd1 == geom.columns;
		end
		case (state_q)
			ST_READ: k_q <= 4'd1;
			ST_CALC: begin
				if (k_q != 4'd10) k_q <= k_q + 4'd1;
				if (k_q == 4'd5) centre_q <= rd_s1;
				if (k_q >= 4'd1 && rd_s1 != missing && kv_d) begin
					acc_q <= acc_q + AB'($signed(rd_s1) * $signed({1'b0, w_d}));
					tot_q <= tot_q + TOT_BITS'(w_d);
				end
				if (k_q == 4'd10) begin
					neg_q <= acc_q < 0;
					num_q <= NB'(2) * NB'(acc_q < 0 ? -acc_q : acc_q) + NB'(tot_q);
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= 7'(NB);
				end
			end
			ST_DIV: begin
				if (bit_q != 7'd0) begin
					bit_q <= bit_q - 7'd1;
					num_q <= num_q << 1;
					if (!trial[NB]) begin
						rem_q <= trial[NB-1:0];
						quo_q <= {quo_q[QB-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[NB-2:0], num_q[NB-1]};
						quo_q <= {quo_q[QB-2:0], 1'b0};
					end
				end else if (emit_free) begin
					ohas_q <= 1'b1;
					olast_q <= last_q;
					oval_q <= (centre_q == missing || tot_q == '0) ? centre_q : qsat;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		kv_d <= kvalid && k_q <= 4'd8;
		w_d <= wsel;
	end

	assign out_valid = ovalid_q;
	assign out_has = ohas_q;
	assign out_value = oval_q;
	assign out_last = olast_q;

	ast_pend: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pend_q) <= BUF_LEN) else $error("ring overflow");
	ast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RUN |-> !in_ready) else $error("accept while busy");
	ast_hold: assert property (@(posedge clk) disable iff (!arst_n || clear)
		out_valid && !out_ready |=> out_valid) else $error("result lost");
endmodule

// ----- hw/rtl/masked_grid_smoother_unit.sv -----
// top level of the masked grid smoother
`timescale 1ns / 1ps
// masked 3x3 grid smoother
// samples enter on the in channel in raster order (cmd 0) or as flush
// tokens (cmd 1); results leave on the out channel with value and frame_last
// config writes go on the cfg channel while the block is idle; a write to
// columns, rows or pass count drops all pending stream state
// a front end keeps the registers and a four deep token queue, so input is
// taken while the back end is busy or the receiver stalls
// each pass holds a ring of 2*MAX_COLUMNS+4 samples in memory; an emitted
// point in its pass takes a read state, the neighbor gather from the single
// read port, SAMPLE_BITS + 26 bit serial divider steps and the emit step
// a token that emits nothing passes a stage through its output register
// with pass count zero samples are copied through a register and flushes dropped
// latency is a row plus one sample per pass, plus the per-point work
// reset clears all control state; no memory clearing pass is needed
// a stalled receiver backs up the stages and then the queue
module masked_grid_smoother_unit #(
	parameter int MAX_COLUMNS = mgs_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_PASSES = mgs_pkg::MAX_PASSES_DEF,
	parameter int SAMPLE_BITS = mgs_pkg::SAMPLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic signed [SAMPLE_BITS-1:0] sample,
	output logic out_valid,
	input logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic frame_last
);
	import mgs_pkg::*;
	geom_t geom;
	logic signed [SAMPLE_BITS-1:0] missing;
	logic clear;
	logic tok_valid, tok_ready, tok_has;
	logic signed [SAMPLE_BITS-1:0] tok_value;
	logic sv [MAX_PASSES+1];
	logic sr [MAX_PASSES+1];
	logic sh [MAX_PASSES+1];
	logic signed [SAMPLE_BITS-1:0] sd [MAX_PASSES+1];
	logic sl [MAX_PASSES+1];
	logic [15:0] crow_q;
	logic [8:0] ccol_q;
	logic copy_mode;
	logic cvalid_q;
	logic signed [SAMPLE_BITS-1:0] cval_q;
	logic clast_q;
	logic ctake;

	mgs_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_PASSES(MAX_PASSES),
		.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .cmd, .sample, .geom, .missing, .clear,
		.tok_valid, .tok_ready, .tok_has, .tok_value);

	assign copy_mode = geom.passes == 3'd0;
	assign sv[0] = tok_valid && !copy_mode;
	assign sh[0] = tok_has;
	assign sd[0] = tok_value;
	assign sl[0] = 1'b0;

	for (genvar g = 0; g < MAX_PASSES; g++) begin : g_stage
		logic active;
		logic ir;
		logic ov, oh, ol;
		logic signed [SAMPLE_BITS-1:0] od;
		assign active = 32'(geom.passes) > g;
		mgs_stage #(.MAX_COLUMNS(MAX_COLUMNS), .SAMPLE_BITS(SAMPLE_BITS)) u_stage (
			.clk, .arst_n, .geom, .missing, .clear,
			.in_valid(sv[g] && active), .in_ready(ir), .in_has(sh[g]), .in_value(sd[g]),
			.out_valid(ov), .out_ready(sr[g+1] || !active), .out_has(oh),
			.out_value(od), .out_last(ol));
		assign sr[g] = active ? ir : sr[g+1];
		assign sv[g+1] = active ? ov : sv[g];
		assign sh[g+1] = active ? oh : sh[g];
		assign sd[g+1] = active ? od : sd[g];
		assign sl[g+1] = active ? ol : sl[g];
	end

	assign sr[MAX_PASSES] = !sh[MAX_PASSES] || out_ready;
	assign ctake = tok_valid && copy_mode && (!cvalid_q || out_ready);
	assign tok_ready = copy_mode ? (!cvalid_q || out_ready) : sr[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crow_q <= '0;
			ccol_q <= '0;
			cvalid_q <= 1'b0;
		end else if (clear) begin
			crow_q <= '0;
			ccol_q <= '0;
			cvalid_q <= 1'b0;
		end else begin
			if (out_ready) cvalid_q <= 1'b0;
			if (ctake && tok_has) begin
				cvalid_q <= 1'b1;
				if (ccol_q + 9'd1 >= geom.columns) begin
					ccol_q <= '0;
					crow_q <= (crow_q + 16'd1 >= geom.rows) ? 16'd0 : crow_q + 16'd1;
				end else begin
					ccol_q <= ccol_q + 9'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctake && tok_has) begin
			cval_q <= tok_value;
			clast_q <= crow_q + 16'd1 == geom.rows && ccol_q + 9'd1 == geom.columns;
		end
	end

	assign out_valid = copy_mode ? cvalid_q : (sv[MAX_PASSES] && sh[MAX_PASSES]);
	assign value = copy_mode ? cval_q : sd[MAX_PASSES];
	assign frame_last = copy_mode ? clast_q : sl[MAX_PASSES];

	ast_copy: assert property (@(posedge clk) disable iff (!arst_n)
		copy_mode |-> !sv[0]) else $error("stage fed in copy mode");
	ast_stall: assert property (@(posedge clk) disable iff (!arst_n || clear)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	ast_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready) else $error("cfg refused");
endmodule

// ----- bench/tb_masked_grid_smoother_unit.sv -----
// testbench for masked_grid_smoother_unit: random grids checked against a smoothing predictor
`timescale 1ns / 1ps
module tb_masked_grid_smoother_unit;
	import mgs_pkg::*;

	localparam int RING_LEN = 2 * MAX_COLUMNS_DEF + 4;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int ITEM_TARGET = 1650;

	class grid_smooth_tracker;
		int cols, rows, weight, passes, miss;
		int ring[MAX_PASSES_DEF][RING_LEN];
		int head[MAX_PASSES_DEF], cnt[MAX_PASSES_DEF];
		int at_row[MAX_PASSES_DEF], at_col[MAX_PASSES_DEF];
		int copy_row, copy_col;
		int want_value[$];
		bit want_last[$];
		int errors, matched;

		function new();
			cols = 256;
			rows = 256;
			weight = 4096;
			passes = 1;
			miss = -32768;
			errors = 0;
			matched = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			for (int s = 0; s < MAX_PASSES_DEF; s++) begin
				head[s] = 0;
				cnt[s] = 0;
				at_row[s] = 0;
				at_col[s] = 0;
				for (int i = 0; i < RING_LEN; i++)
					ring[s][i] = 0;
			end
			copy_row = 0;
			copy_col = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] d);
			case (idx)
				REG_COLUMNS: begin
					cols = (d[8:0] < 2) ? 2 : (d[8:0] > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF
						: int'(d[8:0]);
					clear_stream();
				end
				REG_ROWS: begin
					rows = (d < 2) ? 2 : int'(d);
					clear_stream();
				end
				REG_WEIGHT: weight = int'(d);
				REG_PASSES: begin
					passes = (d[2:0] > MAX_PASSES_DEF) ? MAX_PASSES_DEF : int'(d[2:0]);
					clear_stream();
				end
				REG_MISSING: miss = int'($signed(d));
				default: ;
			endcase
		endfunction

		function void step_pos(inout int r, inout int c);
			c++;
			if (c >= cols) begin
				c = 0;
				r++;
				if (r >= rows)
					r = 0;
			end
		endfunction

		function int smooth_point(int s, int r, int c);
			int base, centre, v, w;
			longint acc, tot, mag, q;
			base = head[s] + RING_LEN - cols - 1;
			centre = ring[s][head[s] % RING_LEN];
			acc = 0;
			tot = 0;
			if (centre == miss)
				return centre;
			for (int dr = 0; dr < 3; dr++)
				for (int dc = 0; dc < 3; dc++) begin
					if ((dr == 0 && r == 0) || (dr == 2 && r + 1 >= rows))
						continue;
					if ((dc == 0 && c == 0) || (dc == 2 && c + 1 >= cols))
						continue;
					v = ring[s][(base + dr * cols + dc) % RING_LEN];
					if (v == miss)
						continue;
					if (dr == 1 && dc == 1)
						w = weight;
					else if (dr == 1 || dc == 1)
						w = EDGE_W;
					else
						w = DIAG_W;
					acc += longint'(w) * v;
					tot += w;
				end
			if (tot == 0)
				return centre;
			mag = (acc < 0) ? -acc : acc;
			mag = (2 * mag + tot) / (2 * tot);
			q = (acc < 0) ? -mag : mag;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			return int'(q);
		endfunction

		function bit run_stage(int s, bit has, inout int v, inout bit last);
			int need;
			if (has) begin
				ring[s][(head[s] + cnt[s]) % RING_LEN] = v;
				cnt[s]++;
			end
			if (cnt[s] == 0)
				return 0;
			need = ((at_row[s] + 1 < rows) ? cols : 0) + ((at_col[s] + 1 < cols) ? 1 : 0);
			if (cnt[s] <= need)
				return 0;
			v = smooth_point(s, at_row[s], at_col[s]);
			last = (at_row[s] + 1 == rows && at_col[s] + 1 == cols);
			head[s] = (head[s] + 1) % RING_LEN;
			cnt[s]--;
			step_pos(at_row[s], at_col[s]);
			return 1;
		endfunction

		function void take_item(bit flush, int smp);
			int v;
			bit last, has;
			v = smp;
			last = 0;
			if (passes == 0) begin
				if (flush)
					return;
				last = (copy_row + 1 == rows && copy_col + 1 == cols);
				step_pos(copy_row, copy_col);
			end else begin
				has = !flush;
				for (int s = 0; s < passes; s++)
					has = run_stage(s, has, v, last);
				if (!has)
					return;
			end
			want_value.push_back(v);
			want_last.push_back(last);
		endfunction

		function void check_result(int v, bit l);
			int ev;
			bit el;
			if (want_value.size() == 0) begin
				$error("result with nothing expected: value %0d frame_last %0b", v, l);
				errors++;
				return;
			end
			ev = want_value.pop_front();
			el = want_last.pop_front();
			if (ev != v) begin
				$error("value: expected %0d, actual %0d", ev, v);
				errors++;
			end
			if (el != l) begin
				$error("frame_last: expected %0b, actual %0b", el, l);
				errors++;
			end
			if (ev == v && el == l)
				matched++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic signed [15:0] sample;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] value;
	logic frame_last;

	grid_smooth_tracker tracker;
	int items_sent;
	int phases_run;
	bit calm;
	bit long_hold;

	masked_grid_smoother_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.frame_last(frame_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#15_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver side
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_result(int'(value), frame_last);
			@(negedge clk);
			if (long_hold) begin
				long_hold = 0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.write_reg(idx, d);
		@(negedge clk);
	endtask

	task automatic program_grid(logic [15:0] c, logic [15:0] r, logic [15:0] w,
		logic [15:0] p, logic [15:0] m);
		write_reg(REG_COLUMNS, c);
		write_reg(REG_ROWS, r);
		write_reg(REG_WEIGHT, w);
		write_reg(REG_PASSES, p);
		write_reg(REG_MISSING, m);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(bit c, logic [15:0] s);
		in_valid <= 1'b1;
		cmd <= c;
		sample <= s;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_item(c, int'($signed(s)));
		items_sent++;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.want_value.size() != 0)
			@(negedge clk);
		repeat (2500) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1: return tracker.miss[15:0];
			2: return 16'h7fff;
			3: return 16'h8000;
			4: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int cols, rows, frames, drain, pts;
		logic [15:0] c_reg, r_reg, w_reg, p_reg, m_reg;
		tracker = new();
		items_sent = 0;
		phases_run = 0;
		calm = 0;
		long_hold = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = 1'b0;
		sample = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 3x3 grid, zero centre weight, corner surrounded by missing points
		program_grid(16'd3, 16'd3, 16'd0, 16'd1, 16'h8000);
		send_item(0, 16'h7fff);
		send_item(0, 16'h8000);
		send_item(0, 16'hffff);
		send_item(0, 16'h8000);
		send_item(0, 16'h8000);
		send_item(0, 16'd100);
		send_item(0, 16'h8001);
		send_item(0, 16'd7);
		send_item(0, 16'd0);
		repeat (6) send_item(1, 16'hffff);
		settle();
		// plain copy, flushes dropped, ignored register index
		write_reg(REG_PASSES, 16'd0);
		write_reg(REG_UNUSED, 16'hffff);
		cfg_valid <= 1'b0;
		send_item(0, 16'h8000);
		send_item(1, 16'd1);
		send_item(0, 16'h7fff);
		send_item(0, 16'h1234);
		send_item(0, 16'h8000);
		settle();
		phases_run = 2;

		while (items_sent < ITEM_TARGET) begin
			if (items_sent > ITEM_TARGET - 250)
				calm = 1;
			case ($urandom_range(0, 9))
				0: c_reg = 16'($urandom_range(0, 1));
				1: c_reg = 16'd511;
				default: c_reg = 16'($urandom_range(2, 9));
			endcase
			case ($urandom_range(0, 9))
				0: r_reg = 16'($urandom_range(0, 1));
				1: r_reg = 16'hffff;
				default: r_reg = 16'($urandom_range(2, 6));
			endcase
			case ($urandom_range(0, 5))
				0: w_reg = 16'd0;
				1: w_reg = 16'hffff;
				2: w_reg = 16'd4096;
				default: w_reg = 16'($urandom);
			endcase
			p_reg = 16'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: m_reg = 16'h8000;
				1: m_reg = 16'h7fff;
				2: m_reg = 16'($urandom_range(0, 15));
				default: m_reg = 16'($urandom);
			endcase
			if (c_reg > 9) begin
				r_reg = 16'd2;
				p_reg = 16'd1;
			end
			program_grid(c_reg, r_reg, w_reg, p_reg, m_reg);
			cols = tracker.cols;
			rows = (tracker.rows > 8) ? 3 : tracker.rows;
			frames = (cols > 9) ? 1 : $urandom_range(1, 3);
			if (phases_run == 4)
				long_hold = 1;
			for (int f = 0; f < frames; f++) begin
				pts = cols * rows;
				if ($urandom_range(0, 9) == 0)
					pts = $urandom_range(1, pts);
				for (int i = 0; i < pts; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_item(1, 16'($urandom));
					send_item(0, pick_sample());
				end
			end
			drain = (cols > 9) ? 20 : tracker.passes * (cols + 1) + 2;
			repeat (drain) send_item(1, 16'($urandom));
			settle();
			phases_run++;
		end

		$display("covered %0d input items over %0d register settings", items_sent, phases_run);
		$display("%0d results matched, %0d mismatches", tracker.matched, tracker.errors);
		if (tracker.errors == 0 && tracker.want_value.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
